>>> hw/rtl/fcr_pkg.sv
// shared types and constants for the framed config receiver
// no dependencies
package fcr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int IDX_W           = 6;
  localparam int CNT_W           = 32;
  localparam int LEN_W           = 16;
  localparam int CFG_IDX_W       = 4;
  localparam int DATA_W          = 80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 4'd0,
    REG_HEADER_SECOND = 4'd1,
    REG_FOOTER_FIRST  = 4'd2,
    REG_FOOTER_SECOND = 4'd3,
    REG_UPDATE_CODE   = 4'd4,
    REG_UPDATE_LENGTH = 4'd5,
    REG_ACK_CODE      = 4'd6,
    REG_NACK_CODE     = 4'd7
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] FOOTER_FIRST_RST  = 8'd13;
  localparam logic [BYTE_W-1:0] FOOTER_SECOND_RST = 8'd10;
  localparam logic [BYTE_W-1:0] UPDATE_CODE_RST   = 8'd1;
  localparam logic [IDX_W-1:0]  UPDATE_LENGTH_RST = 6'd32;
  localparam logic [BYTE_W-1:0] ACK_CODE_RST      = 8'd6;
  localparam logic [BYTE_W-1:0] NACK_CODE_RST     = 8'd21;

  // positions within a response frame
  localparam logic [2:0] RESP_HDR1  = 3'd0;
  localparam logic [2:0] RESP_HDR2  = 3'd1;
  localparam logic [2:0] RESP_CODE  = 3'd2;
  localparam logic [2:0] RESP_FOOT1 = 3'd3;
  localparam logic [2:0] RESP_FOOT2 = 3'd4;

  typedef struct packed {
    logic             load_cmd;
    logic             load_len_lo;
    logic             load_len_hi;
    logic             store_byte;
    logic             load_check;
    logic             inc_err;
    logic             inc_acc;
    logic             rd_en;
    logic             emit_load;
    logic             emit_kind;
    logic             emit_last;
    logic             use_ack;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic             hdr1_match;
    logic             hdr2_match;
    logic             foot1_match;
    logic             foot2_match;
    logic             len_ok;
    logic             payload_done;
    logic             frame_good;
    logic             out_busy;
    logic [IDX_W-1:0] pay_last;
  } stat_t;

endpackage

>>> hw/rtl/fcr_ram.sv
// generic single write port ram with registered read
// no dependencies
module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fcr_ctrl.sv
// frame parse and response sequencing state machine
// depends on fcr_pkg
module fcr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fcr_pkg::stat_t stat,
  output fcr_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    P_HDR1, P_HDR2, P_CMD, P_LENL, P_LENH, P_PAY, P_CHECK, P_FOOT1, P_FOOT2,
    E_RD, E_PAY, E_RESP
  } state_t;

  state_t                    state, state_next;
  logic [fcr_pkg::IDX_W-1:0] cnt, cnt_next;
  logic                      use_ack, use_ack_next;
  logic                      fire;

  always_comb begin
    in_ready = (state != E_RD) && (state != E_PAY) && (state != E_RESP);
    fire = in_valid && in_ready;
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    use_ack_next = use_ack;
    cmd          = '0;
    cmd.cnt      = cnt;
    cmd.use_ack  = use_ack;
    unique case (state)
      P_HDR1: begin
        if (fire && stat.hdr1_match) state_next = P_HDR2;
      end
      P_HDR2: begin
        if (fire) state_next = stat.hdr2_match ? P_CMD : P_HDR1;
      end
      P_CMD: begin
        if (fire) begin
          cmd.load_cmd = 1'b1;
          state_next = P_LENL;
        end
      end
      P_LENL: begin
        if (fire) begin
          cmd.load_len_lo = 1'b1;
          state_next = P_LENH;
        end
      end
      P_LENH: begin
        if (fire) begin
          cmd.load_len_hi = 1'b1;
          if (stat.len_ok) begin
            state_next = P_PAY;
          end else begin
            cmd.inc_err = 1'b1;
            state_next = P_HDR1;
          end
        end
      end
      P_PAY: begin
        if (fire) begin
          cmd.store_byte = 1'b1;
          if (stat.payload_done) state_next = P_CHECK;
        end
      end
      P_CHECK: begin
        if (fire) begin
          cmd.load_check = 1'b1;
          state_next = P_FOOT1;
        end
      end
      P_FOOT1: begin
        if (fire) begin
          if (stat.foot1_match) begin
            state_next = P_FOOT2;
          end else begin
            cmd.inc_err = 1'b1;
            state_next = P_HDR1;
          end
        end
      end
      P_FOOT2: begin
        if (fire) begin
          cnt_next = '0;
          if (!stat.foot2_match) begin
            cmd.inc_err = 1'b1;
            state_next = P_HDR1;
          end else if (stat.frame_good) begin
            cmd.inc_acc = 1'b1;
            use_ack_next = 1'b1;
            state_next = E_RD;
          end else begin
            cmd.inc_err = 1'b1;
            use_ack_next = 1'b0;
            state_next = E_RESP;
          end
        end
      end
      E_RD: begin
        cmd.rd_en = 1'b1;
        state_next = E_PAY;
      end
      E_PAY: begin
        if (!stat.out_busy) begin
          cmd.emit_load = 1'b1;
          cmd.emit_kind = 1'b1;
          if (cnt == stat.pay_last) begin
            cnt_next = '0;
            state_next = E_RESP;
          end else begin
            cnt_next = cnt + 1'b1;
            state_next = E_RD;
          end
        end
      end
      E_RESP: begin
        if (!stat.out_busy) begin
          cmd.emit_load = 1'b1;
          if (cnt[2:0] == fcr_pkg::RESP_FOOT2) begin
            cmd.emit_last = 1'b1;
            state_next = P_HDR1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = P_HDR1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= P_HDR1;
      cnt     <= '0;
      use_ack <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      use_ack <= use_ack_next;
    end
  end

endmodule

>>> hw/rtl/fcr_dpath.sv
// config registers, frame fields, payload store, counters and output register
// depends on fcr_pkg and fcr_ram
module fcr_dpath #(
  parameter int MAX_PAYLOAD = fcr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_fire,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic [fcr_pkg::BYTE_W-1:0]    in_byte,
  input  fcr_pkg::cmd_t                 cmd,
  output fcr_pkg::stat_t                stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic                          out_last,
  output logic [fcr_pkg::DATA_W-1:0]    out_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int FW = $clog2(MAX_PAYLOAD + 1);

  logic [fcr_pkg::BYTE_W-1:0] header_first, header_second, footer_first, footer_second;
  logic [fcr_pkg::BYTE_W-1:0] update_code, ack_code, nack_code;
  logic [fcr_pkg::IDX_W-1:0]  update_length;

  logic [fcr_pkg::BYTE_W-1:0] frame_command, received_check, running_xor;
  logic [fcr_pkg::LEN_W-1:0]  frame_length, len_full;
  logic [FW-1:0]              fill_index;
  logic [FW:0]                fill_inc;
  logic [fcr_pkg::CNT_W-1:0]  accepted_count, error_count;
  logic [fcr_pkg::BYTE_W-1:0] rd_data, emit_byte;

  logic [fcr_pkg::BYTE_W-1:0] out_byte;
  logic [fcr_pkg::IDX_W-1:0]  out_idx;
  logic [fcr_pkg::CNT_W-1:0]  out_acc, out_err;

  fcr_ram #(
    .WIDTH(fcr_pkg::BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_byte),
    .waddr(fill_index[AW-1:0]),
    .wdata(in_byte),
    .re   (cmd.rd_en),
    .raddr(cmd.cnt[AW-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    len_full = {in_byte, frame_length[7:0]};
    fill_inc = {1'b0, fill_index} + 1'b1;
    stat.hdr1_match   = (in_byte == header_first);
    stat.hdr2_match   = (in_byte == header_second);
    stat.foot1_match  = (in_byte == footer_first);
    stat.foot2_match  = (in_byte == footer_second);
    stat.len_ok       = (len_full != '0) &&
                        (len_full <= fcr_pkg::LEN_W'(MAX_PAYLOAD));
    stat.payload_done = (fcr_pkg::LEN_W'(fill_inc) >= frame_length) ||
                        (fill_inc >= (FW + 1)'(MAX_PAYLOAD));
    stat.frame_good   = (running_xor == received_check) &&
                        (frame_command == update_code) &&
                        (frame_length == fcr_pkg::LEN_W'(update_length)) &&
                        (frame_length <= fcr_pkg::LEN_W'(MAX_PAYLOAD));
    stat.out_busy     = out_valid && !out_ready;
    stat.pay_last     = frame_length[fcr_pkg::IDX_W-1:0] - 1'b1;
  end

  always_comb begin
    if (cmd.emit_kind) begin
      emit_byte = rd_data;
    end else begin
      case (cmd.cnt[2:0])
        fcr_pkg::RESP_HDR1:  emit_byte = header_first;
        fcr_pkg::RESP_HDR2:  emit_byte = header_second;
        fcr_pkg::RESP_CODE:  emit_byte = cmd.use_ack ? ack_code : nack_code;
        fcr_pkg::RESP_FOOT1: emit_byte = footer_first;
        default:             emit_byte = footer_second;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first   <= fcr_pkg::HEADER_FIRST_RST;
      header_second  <= fcr_pkg::HEADER_SECOND_RST;
      footer_first   <= fcr_pkg::FOOTER_FIRST_RST;
      footer_second  <= fcr_pkg::FOOTER_SECOND_RST;
      update_code    <= fcr_pkg::UPDATE_CODE_RST;
      update_length  <= fcr_pkg::UPDATE_LENGTH_RST;
      ack_code       <= fcr_pkg::ACK_CODE_RST;
      nack_code      <= fcr_pkg::NACK_CODE_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        fcr_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        fcr_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        fcr_pkg::REG_FOOTER_FIRST:  footer_first  <= cfg_data;
        fcr_pkg::REG_FOOTER_SECOND: footer_second <= cfg_data;
        fcr_pkg::REG_UPDATE_CODE:   update_code   <= cfg_data;
        fcr_pkg::REG_UPDATE_LENGTH: update_length <= cfg_data[fcr_pkg::IDX_W-1:0];
        fcr_pkg::REG_ACK_CODE:      ack_code      <= cfg_data;
        fcr_pkg::REG_NACK_CODE:     nack_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_command  <= '0;
      frame_length   <= '0;
      fill_index     <= '0;
      received_check <= '0;
      running_xor    <= '0;
      accepted_count <= '0;
      error_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.load_cmd) frame_command <= in_byte;
      if (cmd.load_len_lo) frame_length <= {8'd0, in_byte};
      if (cmd.load_len_hi) begin
        frame_length <= len_full;
        fill_index   <= '0;
        running_xor  <= '0;
      end
      if (cmd.store_byte) begin
        fill_index  <= fill_inc[FW-1:0];
        running_xor <= running_xor ^ in_byte;
      end
      if (cmd.load_check) received_check <= in_byte;
      if (cmd.inc_err) error_count <= error_count + 1'b1;
      if (cmd.inc_acc) accepted_count <= accepted_count + 1'b1;
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_kind <= cmd.emit_kind;
      out_last <= cmd.emit_last;
      out_byte <= emit_byte;
      out_idx  <= cmd.cnt;
      out_acc  <= accepted_count;
      out_err  <= error_count;
    end
  end

  assign out_data = {2'b00, out_err, out_acc, out_idx, out_byte};

endmodule

>>> hw/rtl/framed_config_receiver.sv
// top level of the framed config receiver: byte stream in, response and config beats out
// depends on fcr_pkg, fcr_ctrl, fcr_dpath, fcr_ram
// input beats are taken back to back; after an update's last footer beat each payload byte is
// read from the store, then emitted; response beats then go one per cycle unless the output
// stalls (a nack sends just the response); no input is taken while results are sequenced
// synchronous active-high reset restores register defaults and clears counts and parse state
module framed_config_receiver #(
  parameter int MAX_PAYLOAD = fcr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // rx_data
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte, byte_index, frames_accepted, errors_seen, zero pad
  output logic [fcr_pkg::DATA_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,   // kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcr_pkg::BYTE_W-1:0]    cfg_data
);

  fcr_pkg::cmd_t  cmd;
  fcr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  fcr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  fcr_dpath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_fire (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_byte  (s_axis_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_kind (m_axis_tuser),
    .out_last (m_axis_tlast),
    .out_data (m_axis_tdata)
  );

endmodule

>>> hw/rtl/fcr_checker.sv
// port-level checks for the framed config receiver, bound to the top level
// depends on fcr_pkg
module fcr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [fcr_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast,
  input logic                       m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      !m_axis_tuser && (m_axis_tdata[13:8] == {3'b000, fcr_pkg::RESP_FOOT2}))
    else $error("tlast on a beat other than the closing response byte");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser |-> !s_axis_tready)
    else $error("input taken while a config beat sequence is in flight");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind framed_config_receiver fcr_checker u_fcr_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
